// ----- rtl/core/brle_pkg.sv -----
// ----------------------------------------------------------------------------
// brle_pkg: shared types and constants of the byte run-length encoder
// Command format between front and back, literal buffer write port,
// state encodings and code constants.
// ----------------------------------------------------------------------------
package brle_pkg;

   localparam int CHUNK    = 128;
   localparam int RUN_BASE = 127;
   localparam int RUN_FULL = 255;
   localparam int CONT_ONE = 129;
   localparam int MAX_RES  = 17;
   localparam int Q_DEPTH  = 4;

   typedef enum logic [1:0] {
      CMD_RUN,
      CMD_LIT,
      CMD_END
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   hdr;
      logic [7:0]   data;
      logic         bank;
   } cmd_type;

   typedef struct packed {
      logic       en;
      logic       bank;
      logic [6:0] addr;
      logic [7:0] data;
   } wr_type;

   typedef struct packed {
      logic en;
      logic bank;
   } done_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_FLUSH,
      OP_CLOSE,
      OP_RUN
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  data;
      logic [7:0]  rc;
   } op_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_OPA,
      F_OPB,
      F_OPC,
      F_END
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_RUN_H,
      B_RUN_B,
      B_LIT_H,
      B_LIT_B
   } back_state_type;

endpackage

// ----- rtl/core/brle_front.sv -----
// ----------------------------------------------------------------------------
// brle_front: input classifier
// Accepts raw bytes, tracks the held byte and repeat code, writes literal
// bytes into the literal buffer and issues run, literal and end commands.
// ----------------------------------------------------------------------------
module brle_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_in_byte,
   input  logic              req_in_final,
   output logic              q_push,
   output brle_pkg::cmd_type q_cmd,
   input  logic              q_full,
   output brle_pkg::wr_type  lit_wr,
   input  brle_pkg::done_type back_done
);
   import brle_pkg::*;

   front_state_type state_ff, state_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic [7:0] rc_ff, rc_in;
   logic [6:0] cnt_ff, cnt_in;
   logic       bank_ff, bank_in;
   logic [1:0] pend_ff, pend_in;
   op_type     opa_ff, opa_in, opb_ff, opb_in, opc_ff, opc_in;
   op_type     cur_op;
   logic       op_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_IDLE;
         held_byte_ff  <= 8'd0;
         held_valid_ff <= 1'b0;
         rc_ff         <= 8'd1;
         cnt_ff        <= 7'd0;
         bank_ff       <= 1'b0;
         pend_ff       <= 2'b00;
      end else begin
         state_ff      <= state_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         rc_ff         <= rc_in;
         cnt_ff        <= cnt_in;
         bank_ff       <= bank_in;
         pend_ff       <= pend_in;
      end
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      opc_ff <= opc_in;
   end

   always_comb begin
      state_in      = state_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      rc_in         = rc_ff;
      cnt_in        = cnt_ff;
      bank_in       = bank_ff;
      pend_in       = pend_ff;
      opa_in        = opa_ff;
      opb_in        = opb_ff;
      opc_in        = opc_ff;
      req_stall     = (state_ff != F_IDLE);
      q_push        = 1'b0;
      q_cmd         = '{kind: CMD_END, hdr: 8'd0, data: 8'd0, bank: bank_ff};
      lit_wr        = '{en: 1'b0, bank: bank_ff, addr: cnt_ff, data: 8'd0};
      op_done       = 1'b0;
      cur_op        = '{kind: OP_NONE, data: 8'd0, rc: 8'd0};

      if (back_done.en) begin
         pend_in[back_done.bank] = 1'b0;
      end

      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               opa_in = '{kind: OP_NONE, data: 8'd0, rc: 8'd0};
               opb_in = '{kind: OP_NONE, data: 8'd0, rc: 8'd0};
               opc_in = '{kind: OP_NONE, data: 8'd0, rc: 8'd0};
               if (!held_valid_ff) begin
                  held_byte_in  = req_in_byte;
                  held_valid_in = 1'b1;
                  rc_in         = 8'd1;
               end else if (req_in_byte == held_byte_ff) begin
                  if (rc_ff == 8'd1) begin
                     opa_in.kind = OP_FLUSH;
                     rc_in       = 8'd2;
                  end else if (rc_ff == 8'd0) begin
                     rc_in = 8'(CONT_ONE);
                  end else if (rc_ff >= 8'(CHUNK)) begin
                     rc_in = 8'd2;
                  end else begin
                     rc_in = rc_ff + 8'd1;
                  end
                  if (rc_in == 8'(CHUNK)) begin
                     opa_in = '{kind: OP_RUN, data: held_byte_ff, rc: 8'(RUN_FULL)};
                     rc_in  = 8'd0;
                  end
               end else begin
                  opa_in       = '{kind: OP_CLOSE, data: held_byte_ff, rc: rc_ff};
                  held_byte_in = req_in_byte;
                  rc_in        = 8'd1;
               end
               if (req_in_final) begin
                  opb_in        = '{kind: OP_CLOSE, data: held_byte_in, rc: rc_in};
                  opc_in        = '{kind: OP_FLUSH, data: 8'd0, rc: 8'd0};
                  held_byte_in  = 8'd0;
                  held_valid_in = 1'b0;
                  rc_in         = 8'd1;
               end
               state_in = F_OPA;
            end
         end
         F_OPA, F_OPB, F_OPC: begin
            if (state_ff == F_OPA) begin
               cur_op = opa_ff;
            end else if (state_ff == F_OPB) begin
               cur_op = opb_ff;
            end else begin
               cur_op = opc_ff;
            end
            // translate close into literal push or run
            if (cur_op.kind == OP_CLOSE) begin
               if (cur_op.rc == 8'd0) begin
                  cur_op.kind = OP_NONE;
               end else if (cur_op.rc != 8'd1) begin
                  cur_op.kind = OP_RUN;
                  if (cur_op.rc < 8'(CHUNK)) begin
                     cur_op.rc = 8'(RUN_BASE) + cur_op.rc;
                  end else begin
                     cur_op.rc = 8'(CHUNK);
                  end
               end
            end
            case (cur_op.kind)
               OP_NONE: op_done = 1'b1;
               OP_RUN: begin
                  if (!q_full) begin
                     q_push  = 1'b1;
                     q_cmd   = '{kind: CMD_RUN, hdr: cur_op.rc, data: cur_op.data,
                                 bank: bank_ff};
                     op_done = 1'b1;
                  end
               end
               OP_CLOSE: begin
                  if (!q_full && !pend_ff[bank_ff]) begin
                     lit_wr  = '{en: 1'b1, bank: bank_ff, addr: cnt_ff, data: cur_op.data};
                     op_done = 1'b1;
                     if (cnt_ff == 7'd127) begin
                        q_push           = 1'b1;
                        q_cmd            = '{kind: CMD_LIT, hdr: 8'd127, data: 8'd0,
                                             bank: bank_ff};
                        pend_in[bank_ff] = 1'b1;
                        bank_in          = ~bank_ff;
                        cnt_in           = 7'd0;
                     end else begin
                        cnt_in = cnt_ff + 7'd1;
                     end
                  end
               end
               OP_FLUSH: begin
                  if (cnt_ff == 7'd0) begin
                     op_done = 1'b1;
                  end else if (!q_full) begin
                     q_push           = 1'b1;
                     q_cmd            = '{kind: CMD_LIT, hdr: {1'b0, cnt_ff - 7'd1},
                                          data: 8'd0, bank: bank_ff};
                     pend_in[bank_ff] = 1'b1;
                     bank_in          = ~bank_ff;
                     cnt_in           = 7'd0;
                     op_done          = 1'b1;
                  end
               end
               default: op_done = 1'b1;
            endcase
            if (op_done) begin
               if (state_ff == F_OPA) begin
                  state_in = F_OPB;
               end else if (state_ff == F_OPB) begin
                  state_in = F_OPC;
               end else begin
                  state_in = F_END;
               end
            end
         end
         F_END: begin
            if (!q_full) begin
               q_push   = 1'b1;
               q_cmd    = '{kind: CMD_END, hdr: 8'd0, data: 8'd0, bank: bank_ff};
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

endmodule

// ----- rtl/core/brle_queue.sv -----
// ----------------------------------------------------------------------------
// brle_queue: command queue
// Small FIFO that parts the front from the back.
// ----------------------------------------------------------------------------
module brle_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  brle_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output brle_pkg::cmd_type head,
   output logic              empty
);
   import brle_pkg::*;

   localparam int PW = $clog2(Q_DEPTH);

   cmd_type         slot_ff [Q_DEPTH];
   logic [PW-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [PW:0]     cnt_ff, cnt_in;

   assign full  = (cnt_ff == (PW+1)'(Q_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slot_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push && !full) begin
         wp_in = wp_ff + 1'b1;
      end
      if (pop && !empty) begin
         rp_in = rp_ff + 1'b1;
      end
      cnt_in = cnt_ff + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push && !full) begin
         slot_ff[wp_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/core/brle_lit_mem.sv -----
// ----------------------------------------------------------------------------
// brle_lit_mem: literal buffer
// Two banks of 128 literal bytes, one write port, one registered read port.
// ----------------------------------------------------------------------------
module brle_lit_mem (
   input  logic             clock,
   input  brle_pkg::wr_type wr,
   input  logic             rd_bank,
   input  logic [6:0]       rd_addr,
   output logic [7:0]       rd_data
);
   import brle_pkg::*;

   logic [7:0] mem_ff [2*CHUNK];
   logic [7:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[{wr.bank, wr.addr}] <= wr.data;
      end
      rd_data_ff <= mem_ff[{rd_bank, rd_addr}];
   end

endmodule

// ----- rtl/core/brle_back.sv -----
// ----------------------------------------------------------------------------
// brle_back: code byte emitter and lane packer
// Executes commands one code byte per cycle unless stalled by rsp_stall,
// packs bytes into lane words and drives the result register.
// ----------------------------------------------------------------------------
module brle_back #(
   parameter int OUT_LANES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  brle_pkg::cmd_type  q_head,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               rd_bank,
   output logic [6:0]         rd_addr,
   input  logic [7:0]         rd_data,
   output brle_pkg::done_type back_done,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_lane [8],
   output logic [3:0]         rsp_lane_count,
   output logic               rsp_run_end
);
   import brle_pkg::*;

   back_state_type state_ff, state_in;
   logic [7:0] hdr_ff, hdr_in, data_ff, data_in;
   logic       bank_ff, bank_in;
   logic [6:0] idx_ff, idx_in;
   logic [7:0] acc_ff [8];
   logic [7:0] acc_in [8];
   logic [3:0] acc_cnt_ff, acc_cnt_in;
   logic [4:0] res_ff, res_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] out_lane_ff [8];
   logic [3:0] out_cnt_ff;
   logic       out_end_ff;
   logic       out_load, out_load_end, out_free;
   logic       byte_valid, take;
   logic [7:0] byte_val;

   assign out_free       = !out_valid_ff || !rsp_stall;
   assign rsp_valid      = out_valid_ff;
   assign rsp_lane       = out_lane_ff;
   assign rsp_lane_count = out_cnt_ff;
   assign rsp_run_end    = out_end_ff;
   assign rd_bank        = bank_ff;

   always_comb begin
      state_in     = state_ff;
      hdr_in       = hdr_ff;
      data_in      = data_ff;
      bank_in      = bank_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      acc_cnt_in   = acc_cnt_ff;
      res_in       = res_ff;
      q_pop        = 1'b0;
      back_done    = '{en: 1'b0, bank: bank_ff};
      out_load     = 1'b0;
      out_load_end = 1'b0;
      take         = 1'b0;
      byte_valid   = 1'b0;
      byte_val     = hdr_ff;

      case (state_ff)
         B_RUN_H, B_LIT_H: begin
            byte_valid = 1'b1;
            byte_val   = hdr_ff;
         end
         B_RUN_B: begin
            byte_valid = 1'b1;
            byte_val   = data_ff;
         end
         B_LIT_B: begin
            byte_valid = 1'b1;
            byte_val   = rd_data;
         end
         default: byte_valid = 1'b0;
      endcase

      // pack one byte
      if (byte_valid) begin
         if (acc_cnt_ff == 4'(OUT_LANES)) begin
            if (res_ff == 5'(MAX_RES - 1)) begin
               take = 1'b1;
            end else if (out_free) begin
               take     = 1'b1;
               out_load = 1'b1;
               for (int i = 0; i < 8; i++) begin
                  acc_in[i] = 8'd0;
               end
               acc_in[0]  = byte_val;
               acc_cnt_in = 4'd1;
               res_in     = res_ff + 5'd1;
            end
         end else begin
            take                     = 1'b1;
            acc_in[acc_cnt_ff[2:0]]  = byte_val;
            acc_cnt_in               = acc_cnt_ff + 4'd1;
         end
      end

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               if (q_head.kind == CMD_END) begin
                  if (acc_cnt_ff == 4'd0) begin
                     q_pop  = 1'b1;
                     res_in = 5'd0;
                  end else if (out_free) begin
                     q_pop        = 1'b1;
                     out_load     = 1'b1;
                     out_load_end = 1'b1;
                     res_in       = 5'd0;
                     acc_cnt_in   = 4'd0;
                     for (int i = 0; i < 8; i++) begin
                        acc_in[i] = 8'd0;
                     end
                  end
               end else begin
                  q_pop   = 1'b1;
                  hdr_in  = q_head.hdr;
                  data_in = q_head.data;
                  bank_in = q_head.bank;
                  idx_in  = 7'd0;
                  state_in = (q_head.kind == CMD_RUN) ? B_RUN_H : B_LIT_H;
               end
            end
         end
         B_RUN_H: if (take) state_in = B_RUN_B;
         B_RUN_B: if (take) state_in = B_IDLE;
         B_LIT_H: if (take) state_in = B_LIT_B;
         B_LIT_B: begin
            if (take) begin
               if (idx_ff == hdr_ff[6:0]) begin
                  state_in  = B_IDLE;
                  back_done = '{en: 1'b1, bank: bank_ff};
               end else begin
                  idx_in = idx_ff + 7'd1;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase

      rd_addr = 7'd0;
      if (state_ff == B_LIT_B) begin
         rd_addr = take ? idx_ff + 7'd1 : idx_ff;
      end

      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         acc_cnt_ff   <= 4'd0;
         res_ff       <= 5'd0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            acc_ff[i] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         acc_cnt_ff   <= acc_cnt_in;
         res_ff       <= res_in;
         out_valid_ff <= out_valid_in;
         acc_ff       <= acc_in;
      end
      hdr_ff  <= hdr_in;
      data_ff <= data_in;
      bank_ff <= bank_in;
      idx_ff  <= idx_in;
      if (out_load) begin
         out_lane_ff <= acc_ff;
         out_cnt_ff  <= acc_cnt_ff;
         out_end_ff  <= out_load_end;
      end
   end

`ifndef SYNTHESIS
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      acc_cnt_ff <= 4'(OUT_LANES))
      else $error("lane accumulator overfilled");
   a_res_bound: assert property (@(posedge clock) disable iff (reset)
      res_ff < 5'(MAX_RES))
      else $error("result count per item exceeded");
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      out_load && out_load_end |=> res_ff == 5'd0 && acc_cnt_ff == 4'd0)
      else $error("item end did not clear packer");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result register overwritten while stalled");
`endif

endmodule

// ----- rtl/core/byte_rle_encoder.sv -----
// ----------------------------------------------------------------------------
// byte_rle_encoder: run-length encoder for byte blocks
// Feed one raw byte per item on req_, with req_in_final on the last byte of
// a block. Code bytes (run headers, literal headers and data) come out on
// rsp_ packed into words of OUT_LANES byte lanes, rsp_lane_count valid
// lanes from lane 0, and rsp_run_end on the last word caused by an item.
// Items that cause no code bytes produce no word.
// The front takes a new item only after it has worked through the last one
// and queued its end command; it waits while the command queue is full or
// while the literal bank it must fill is still being read out. The back
// emits one code byte per cycle unless a stalled result word holds it, and
// returns to idle between commands.
// A stalled result word holds; the back and then the front fill up and
// req_stall rises. Synchronous reset empties the queue, drops held bytes
// and pending literals, and returns both parts to idle; no clearing pass.
// ----------------------------------------------------------------------------
module byte_rle_encoder #(
   parameter int OUT_LANES = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_final,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_lane_0,
   output logic [7:0] rsp_lane_1,
   output logic [7:0] rsp_lane_2,
   output logic [7:0] rsp_lane_3,
   output logic [7:0] rsp_lane_4,
   output logic [7:0] rsp_lane_5,
   output logic [7:0] rsp_lane_6,
   output logic [7:0] rsp_lane_7,
   output logic [3:0] rsp_lane_count,
   output logic       rsp_run_end
);
   import brle_pkg::*;

   logic     q_push, q_full, q_pop, q_empty;
   cmd_type  q_cmd, q_head;
   wr_type   lit_wr;
   done_type back_done;
   logic       rd_bank;
   logic [6:0] rd_addr;
   logic [7:0] rd_data;
   logic [7:0] lane [8];

   brle_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .req_in_final (req_in_final),
      .q_push       (q_push),
      .q_cmd        (q_cmd),
      .q_full       (q_full),
      .lit_wr       (lit_wr),
      .back_done    (back_done)
   );

   brle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head     (q_head),
      .empty    (q_empty)
   );

   brle_lit_mem u_mem (
      .clock   (clock),
      .wr      (lit_wr),
      .rd_bank (rd_bank),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   brle_back #(.OUT_LANES(OUT_LANES)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_head         (q_head),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rd_bank        (rd_bank),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .back_done      (back_done),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_lane       (lane),
      .rsp_lane_count (rsp_lane_count),
      .rsp_run_end    (rsp_run_end)
   );

   assign rsp_lane_0 = lane[0];
   assign rsp_lane_1 = lane[1];
   assign rsp_lane_2 = lane[2];
   assign rsp_lane_3 = lane[3];
   assign rsp_lane_4 = lane[4];
   assign rsp_lane_5 = lane[5];
   assign rsp_lane_6 = lane[6];
   assign rsp_lane_7 = lane[7];

endmodule

// ----- tb/byte_rle_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// byte_rle_encoder_tb: self-checking bench for the byte run-length encoder
// Blocks of raw bytes go in on req_ with random gaps. A predictor tracks
// the held byte, the repeat count and the pending literals, and builds the
// code words that each byte causes. Each word taken from rsp_ is compared
// field by field with the oldest prediction. A directed table opens the run.
// ----------------------------------------------------------------------------
module byte_rle_encoder_tb;
   import brle_pkg::*;

   localparam int LANES = 8;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic [7:0] lane [8];
      logic [3:0] count;
      logic       last;
   } word_type;

   typedef struct {
      logic [7:0] value;
      logic       fin;
      int         n_words;
      logic [7:0] first_lane0;
   } row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = '0;
   logic       req_in_final = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b1;
   logic [7:0] rsp_lane [8];
   logic [3:0] rsp_lane_count;
   logic       rsp_run_end;

   byte_rle_encoder #(.OUT_LANES(LANES)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_in_byte(req_in_byte), .req_in_final(req_in_final),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_lane_0(rsp_lane[0]), .rsp_lane_1(rsp_lane[1]),
      .rsp_lane_2(rsp_lane[2]), .rsp_lane_3(rsp_lane[3]),
      .rsp_lane_4(rsp_lane[4]), .rsp_lane_5(rsp_lane[5]),
      .rsp_lane_6(rsp_lane[6]), .rsp_lane_7(rsp_lane[7]),
      .rsp_lane_count(rsp_lane_count), .rsp_run_end(rsp_run_end)
   );

   always #5 clock = ~clock;

   // encoder state copy
   logic [7:0] held_value;
   logic       holding;
   logic [7:0] repeats;
   logic [7:0] pending_lits [128];
   int         n_lits;
   logic [7:0] code_bytes [$];
   word_type   expected_words [$];

   int errors = 0;
   int items_sent = 0;
   int words_seen = 0;
   int blocks_sent = 0;
   int idle_cycles = 0;
   bit hold_off = 1'b0;
   bit stim_done = 1'b0;

   task automatic report(input string what, input int got, input int want);
      $display("mismatch at word %0d: %s got %0d want %0d", words_seen, what, got, want);
      errors++;
   endtask

   function automatic void put_code(logic [7:0] v);
      code_bytes.insert(code_bytes.size(), v);
   endfunction

   function automatic void flush_lits();
      if (n_lits == 0) return;
      put_code(8'(n_lits - 1));
      for (int i = 0; i < n_lits; i++) put_code(pending_lits[i]);
      n_lits = 0;
   endfunction

   function automatic void add_lit(logic [7:0] v);
      pending_lits[n_lits] = v;
      n_lits++;
      if (n_lits >= CHUNK) flush_lits();
   endfunction

   function automatic void close_held();
      if (repeats == 0) return;
      if (repeats == 1) add_lit(held_value);
      else if (repeats < CHUNK) begin
         put_code(8'(RUN_BASE + repeats));
         put_code(held_value);
      end else begin
         put_code(8'(CHUNK));
         put_code(held_value);
      end
   endfunction

   function automatic void clear_encoder();
      held_value = '0;
      holding = 1'b0;
      repeats = 8'd1;
      n_lits = 0;
   endfunction

   // returns the number of words predicted for this item
   function automatic int encode_item(logic [7:0] b, logic fin);
      int n;
      word_type w;
      code_bytes.delete();
      if (!holding) begin
         held_value = b;
         holding = 1'b1;
         repeats = 8'd1;
      end else if (b == held_value) begin
         if (repeats == 1) begin
            flush_lits();
            repeats = 8'd2;
         end else if (repeats == 0) repeats = 8'(CONT_ONE);
         else if (repeats >= CHUNK) repeats = 8'd2;
         else repeats++;
         if (repeats == CHUNK) begin
            put_code(8'(RUN_FULL));
            put_code(held_value);
            repeats = 8'd0;
         end
      end else begin
         close_held();
         held_value = b;
         repeats = 8'd1;
      end
      if (fin) begin
         close_held();
         flush_lits();
         clear_encoder();
      end
      n = (code_bytes.size() + LANES - 1) / LANES;
      if (n > MAX_RES) n = MAX_RES;
      for (int k = 0; k < n; k++) begin
         w.count = 0;
         for (int j = 0; j < 8; j++) begin
            if (j < LANES && code_bytes.size() > 0) begin
               w.lane[j] = code_bytes.pop_front();
               w.count++;
            end else w.lane[j] = '0;
         end
         w.last = (k == n - 1);
         expected_words.insert(expected_words.size(), w);
      end
      return n;
   endfunction

   task automatic send_item(input logic [7:0] b, input logic fin);
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_in_final <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (fin) blocks_sent++;
   endtask

   task automatic idle_gap();
      int g;
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) g = 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic feed(input logic [7:0] b, input logic fin);
      void'(encode_item(b, fin));
      send_item(b, fin);
      idle_gap();
   endtask

   // directed table: after reset, single byte block, runs, literal mix
   row_type rows [16] = '{
      '{8'h00, 1'b1, 1, 8'h00},
      '{8'hFF, 1'b1, 1, 8'h00},
      '{8'h41, 1'b0, 0, 8'h00},
      '{8'h41, 1'b0, 0, 8'h00},
      '{8'h41, 1'b1, 1, 8'h82},
      '{8'h01, 1'b0, 0, 8'h00},
      '{8'h02, 1'b0, 0, 8'h00},
      '{8'h03, 1'b1, 1, 8'h02},
      '{8'h10, 1'b0, 0, 8'h00},
      '{8'h20, 1'b0, 0, 8'h00},
      '{8'h20, 1'b0, 1, 8'h00},
      '{8'h30, 1'b1, -1, 8'h00},
      '{8'h55, 1'b0, 0, 8'h00},
      '{8'hAA, 1'b0, 0, 8'h00},
      '{8'h55, 1'b0, 0, 8'h00},
      '{8'hAA, 1'b1, 1, 8'h03}
   };

   task automatic run_of(input logic [7:0] b, input int len, input logic fin);
      for (int i = 0; i < len; i++) feed(b, fin && i == len - 1);
   endtask

   task automatic literals_of(input int len, input logic fin);
      logic [7:0] v;
      for (int i = 0; i < len; i++) begin
         v = 8'(i * 37 + 5);
         feed(v, fin && i == len - 1);
      end
   endtask

   initial begin
      int n;
      clear_encoder();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) begin
         n = encode_item(rows[i].value, rows[i].fin);
         if (rows[i].n_words >= 0 && n != rows[i].n_words)
            report("table word count", n, rows[i].n_words);
         if (rows[i].n_words == 1 && expected_words[$].lane[0] != rows[i].first_lane0)
            report("table header", expected_words[$].lane[0], rows[i].first_lane0);
         send_item(rows[i].value, rows[i].fin);
         idle_gap();
      end
      // full literal chunk, then a full run chunk with one byte left over
      literals_of(128, 1'b0);
      run_of(8'h66, 129, 1'b1);
      // random blocks, mostly mixes of runs and literal stretches
      hold_off = 1'b1;
      while (items_sent < 310) begin
         int parts;
         parts = $urandom_range(1, 3);
         for (int p = 0; p < parts; p++) begin
            logic last;
            last = (p == parts - 1);
            case ($urandom_range(0, 4))
               0: run_of(8'($urandom), $urandom_range(1, 8), last);
               1: literals_of($urandom_range(1, 10), last);
               default: begin
                  int len;
                  len = $urandom_range(1, 12);
                  for (int i = 0; i < len; i++)
                     feed(8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1)),
                        last && i == len - 1);
               end
            endcase
         end
      end
      req_valid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver: random stalls plus one long hold-off
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            hold_off = 1'b0;
            rsp_stall <= 1'b1;
            repeat (400) @(posedge clock);
         end
         if ($urandom_range(0, 2) == 0)
            rsp_stall <= 1'b0;
         else
            rsp_stall <= ($urandom_range(0, 11) == 0) ? 1'b1 : 1'($urandom_range(0, 1));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         word_type w;
         if (expected_words.size() == 0) begin
            report("unexpected word, count", rsp_lane_count, 0);
         end else begin
            w = expected_words.pop_front();
            for (int j = 0; j < 8; j++)
               if (rsp_lane[j] !== w.lane[j])
                  report($sformatf("lane %0d", j), rsp_lane[j], w.lane[j]);
            if (rsp_lane_count !== w.count) report("lane count", rsp_lane_count, w.count);
            if (rsp_run_end !== w.last) report("run end", rsp_run_end, w.last);
         end
         words_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("sent %0d bytes in %0d blocks, checked %0d code words",
         items_sent, blocks_sent, words_seen);
      $display("covered runs and literal stretches across chunk edges, single-byte blocks");
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
